### design/kvfe_pkg.sv
package kvfe_pkg;

  // Widths of the stream payload, the configuration port and the key length, and the key size in bytes
  localparam int unsigned KVFE_BYTE_W     = 8;
  localparam int unsigned KVFE_CFG_DATA_W = 64;
  localparam int unsigned KVFE_CFG_ADDR_W = 2;
  localparam int unsigned KVFE_KEYLEN_W   = 4;
  localparam int unsigned KVFE_KEY_BYTES  = 8;

  // Register reset values
  localparam logic [KVFE_KEYLEN_W-1:0] KVFE_KEYLEN_RST = 4'd1;
  localparam logic [KVFE_BYTE_W-1:0]   KVFE_SEP_RST    = 8'd61;  // '='
  localparam logic [KVFE_BYTE_W-1:0]   KVFE_TERM_RST   = 8'd38;  // '&'

  // Digit-range end rule, ',' through '9'
  localparam logic [KVFE_BYTE_W-1:0] KVFE_RANGE_LOW  = 8'd44;
  localparam logic [KVFE_BYTE_W-1:0] KVFE_RANGE_HIGH = 8'd57;

  typedef enum logic [KVFE_CFG_ADDR_W-1:0] {
    REG_KEY_BYTES  = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_SEPARATOR  = 2'd2,
    REG_TERMINATOR = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Window status handed to the phase controller
  typedef struct packed {
    logic match;   // key matches the window including the current byte
    logic first;   // current byte is the first of the string
  } win_status_t;

endpackage

### design/kvfe_window.sv
module kvfe_window #(
  parameter int unsigned KEY_BYTES = kvfe_pkg::KVFE_KEY_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                clear,
  input  logic [kvfe_pkg::KVFE_BYTE_W-1:0]    data_byte,
  input  logic [KEY_BYTES*8-1:0]              key_bytes,
  input  logic [kvfe_pkg::KVFE_KEYLEN_W-1:0]  key_length,
  output kvfe_pkg::win_status_t               status
);
  import kvfe_pkg::*;

  localparam int unsigned WIN_W  = KEY_BYTES * 8;
  localparam int unsigned FILL_W = $clog2(KEY_BYTES + 1);

  logic [WIN_W-1:0]             recent_bytes;
  logic [WIN_W-1:0]             recent_bytes_next;
  logic [WIN_W+KVFE_BYTE_W-1:0] shifted;
  logic [FILL_W-1:0]            fill_count;
  logic [FILL_W-1:0]            fill_count_next;
  logic                         match;

  assign shifted           = {recent_bytes, data_byte};
  assign recent_bytes_next = shifted[WIN_W-1:0];
  assign fill_count_next   = (fill_count < FILL_W'(KEY_BYTES)) ?
                             fill_count + FILL_W'(1) : fill_count;

  // One compare per possible key length, newest byte holds the key's last char
  always_comb begin
    logic hit;
    match = 1'b0;
    for (int l = 1; l <= KEY_BYTES; l++) begin
      hit = (key_length == KVFE_KEYLEN_W'(l)) && (fill_count_next >= FILL_W'(l));
      for (int i = 0; i < KEY_BYTES; i++) begin
        if (i < l) begin
          if (key_bytes[8*i +: 8] != recent_bytes_next[8*(l-1-i) +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      match = match | hit;
    end
  end

  assign status.match = match;
  assign status.first = (fill_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes <= '0;
      fill_count   <= '0;
    end else if (advance) begin
      if (clear) begin
        recent_bytes <= '0;
        fill_count   <= '0;
      end else begin
        recent_bytes <= recent_bytes_next;
        fill_count   <= fill_count_next;
      end
    end
  end

endmodule

### design/kvfe_ctrl.sv
module kvfe_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [kvfe_pkg::KVFE_BYTE_W-1:0]    data_byte,
  input  logic                                last_byte,
  input  kvfe_pkg::win_status_t               status,
  input  logic [kvfe_pkg::KVFE_KEYLEN_W-1:0]  key_length,
  input  logic [kvfe_pkg::KVFE_BYTE_W-1:0]    separator_char,
  input  logic [kvfe_pkg::KVFE_BYTE_W-1:0]    terminator_char,
  output logic                                emit,
  output logic                                key_found
);
  import kvfe_pkg::*;

  phase_t phase;
  phase_t phase_eff;
  phase_t phase_next;
  logic   ends;

  // empty key: the first byte is already examined for the separator
  assign phase_eff = (phase == PH_SEARCH && key_length == '0 && status.first) ?
                     PH_SKIP : phase;

  assign ends = (terminator_char != '0) ? (data_byte == terminator_char) :
                ((data_byte < KVFE_RANGE_LOW) || (data_byte > KVFE_RANGE_HIGH));

  // next state
  always_comb begin
    phase_next = phase_eff;
    case (phase_eff)
      PH_SEARCH: if (status.match) phase_next = PH_SKIP;
      PH_SKIP:   if (data_byte == separator_char) phase_next = PH_VALUE;
      PH_VALUE:  if (ends) phase_next = PH_DONE;
      PH_DONE:   phase_next = PH_DONE;
      default:   phase_next = PH_SEARCH;
    endcase
  end

  // outputs
  always_comb begin
    case (phase_eff)
      PH_VALUE: emit = !ends;
      default:  emit = 1'b0;
    endcase
    key_found = last_byte && (phase_next != PH_SEARCH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
    end else if (advance) begin
      phase <= last_byte ? PH_SEARCH : phase_next;
    end
  end

endmodule

### design/key_value_field_extractor.sv
// Key/value field extractor. Bytes of a text string enter on the s_ stream,
// the final byte of each string marked by s_tlast. The block finds the first
// occurrence of the configured key (up to KEY_BYTES characters) with a
// parallel compare over a window of the most recent bytes, skips to the next
// separator byte, then passes on the value bytes that follow until the
// terminator byte (terminator 0: until a byte outside ',' .. '9'). A result
// transfer on the m_ stream carries either a value byte (m_tuser[0] set) or
// the end-of-string report (m_tlast set, m_tuser[1] = key found), or both
// when the value runs into the last byte. Bytes that produce nothing are
// absorbed silently. Throughput is one byte per clock while not stalled: an input
// register feeds the window compare and phase logic, which load the output
// register in the same cycle; m_tvalid comes from that output register, which follows the input register.
// The block only stalls when the output register is full and m_tready is
// low. Configuration (cfg_we/cfg_addr/cfg_data) should change only while the
// stream is idle; all string state clears after each last byte.
module key_value_field_extractor #(
  parameter int unsigned KEY_BYTES = kvfe_pkg::KVFE_KEY_BYTES
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [kvfe_pkg::KVFE_CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [kvfe_pkg::KVFE_CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,   // [7:0] data_byte
  input  logic                                  s_tlast,   // last_byte
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata,   // [7:0] value_byte
  output logic [1:0]                            m_tuser,   // [0] value_valid, [1] key_found
  output logic                                  m_tlast    // string_done
);
  import kvfe_pkg::*;

  localparam int unsigned KEY_W = KEY_BYTES * 8;

  // configuration registers
  logic [KEY_W-1:0]         key_bytes;
  logic [KVFE_KEYLEN_W-1:0] key_length;
  logic [KVFE_BYTE_W-1:0]   separator_char;
  logic [KVFE_BYTE_W-1:0]   terminator_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes       <= '0;
      key_length      <= KVFE_KEYLEN_RST;
      separator_char  <= KVFE_SEP_RST;
      terminator_char <= KVFE_TERM_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_KEY_BYTES:  key_bytes       <= cfg_data[KEY_W-1:0];
        REG_KEY_LENGTH: key_length      <= cfg_data[KVFE_KEYLEN_W-1:0];
        REG_SEPARATOR:  separator_char  <= cfg_data[KVFE_BYTE_W-1:0];
        REG_TERMINATOR: terminator_char <= cfg_data[KVFE_BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   in_valid;
  logic [KVFE_BYTE_W-1:0] in_byte;
  logic                   in_last;
  logic                   advance;

  // a byte moves through the logic whenever the result slot is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // window compare and phase control
  win_status_t status;
  logic        emit;
  logic        found;

  kvfe_window #(
    .KEY_BYTES (KEY_BYTES)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .clear      (in_last),
    .data_byte  (in_byte),
    .key_bytes  (key_bytes),
    .key_length (key_length),
    .status     (status)
  );

  kvfe_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .data_byte       (in_byte),
    .last_byte       (in_last),
    .status          (status),
    .key_length      (key_length),
    .separator_char  (separator_char),
    .terminator_char (terminator_char),
    .emit            (emit),
    .key_found       (found)
  );

  // result register: loaded only when the byte produces a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && (emit || in_last)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (emit || in_last)) begin
      m_tdata <= emit ? in_byte : '0;
      m_tuser <= {found, emit};
      m_tlast <= in_last;
    end
  end

endmodule

### design/kvfe_checker.sv
module kvfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  // no empty results
  a_useful: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[0] || m_tlast)
    else $error("result with neither value nor end of string");

  // key found is only reported at end of string
  a_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("key_found without string_done");

  // value byte zero when not a value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
    else $error("value_byte not zero");

  // out of reset: empty and ready
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

bind key_value_field_extractor kvfe_checker u_kvfe_checker (.*);
